### hdl/hufc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hufc_pkg
// Shared types, codes and default sizes for the prefix-code table codec.
// ----------------------------------------------------------------------------
package hufc_pkg;

  localparam int SYMBOL_COUNT_DEF    = 256;
  localparam int MAX_CODE_LENGTH_DEF = 16;

  localparam int OP_W    = 2;
  localparam int SYM_W   = 8;
  localparam int CODE_W  = 16;
  localparam int LEN_W   = 5;
  localparam int STAT_W  = 2;
  localparam int ENTRY_W = LEN_W + CODE_W;

  // item kinds
  localparam logic [OP_W-1:0] OP_WRITE  = 2'd0;
  localparam logic [OP_W-1:0] OP_ENCODE = 2'd1;
  localparam logic [OP_W-1:0] OP_DECODE = 2'd2;

  // result status codes
  localparam logic [STAT_W-1:0] ST_NONE    = 2'd0;
  localparam logic [STAT_W-1:0] ST_DECODED = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMITTED = 2'd2;
  localparam logic [STAT_W-1:0] ST_ERROR   = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [SYM_W-1:0]  symbol;
    logic [CODE_W-1:0] code_bits;
    logic [LEN_W-1:0]  code_length;
    logic              coded_bit;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [SYM_W-1:0]  decoded_symbol;
    logic [CODE_W-1:0] emitted_code;
    logic [LEN_W-1:0]  emitted_length;
  } out_item_t;

  // table update command toward the match array
  typedef struct packed {
    logic              en;
    logic              set;
    logic [SYM_W-1:0]  symbol;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
  } tbl_wr_t;

endpackage
`default_nettype wire

### hdl/hufc_ifs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hufc channel interfaces
// Valid/ready channels carrying codec items and codec results.
// ----------------------------------------------------------------------------
interface hufc_in_if;
  logic               valid;
  logic               ready;
  hufc_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface hufc_out_if;
  logic                valid;
  logic                ready;
  hufc_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### hdl/hufc_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hufc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hufc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 wr_en,
  input  wire logic [AW-1:0]        wr_addr,
  input  wire logic [WIDTH-1:0]     wr_data,
  input  wire logic                 rd_en,
  input  wire logic [AW-1:0]        rd_addr,
  output logic      [WIDTH-1:0]     rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

### hdl/hufc_cam.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hufc_cam
// Code table cells: per-symbol code, length and valid flag, compared in
// parallel against the current partial code.
// ----------------------------------------------------------------------------
module hufc_cam #(
  parameter int SYMBOL_COUNT    = hufc_pkg::SYMBOL_COUNT_DEF,
  parameter int MAX_CODE_LENGTH = hufc_pkg::MAX_CODE_LENGTH_DEF,
  localparam int SW  = $clog2(SYMBOL_COUNT),
  localparam int NLW = $clog2(MAX_CODE_LENGTH + 1)
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire hufc_pkg::tbl_wr_t           wr,
  input  wire logic [MAX_CODE_LENGTH-1:0]  key_code,
  input  wire logic [NLW-1:0]              key_len,
  input  wire logic [SW-1:0]               rd_idx,
  output logic                             rd_valid,
  output logic [SYMBOL_COUNT-1:0]          match
);

  localparam int CLW   = (NLW > hufc_pkg::LEN_W) ? NLW : hufc_pkg::LEN_W;
  localparam int CMP_W = (MAX_CODE_LENGTH > hufc_pkg::CODE_W) ?
                         MAX_CODE_LENGTH : hufc_pkg::CODE_W;

  logic [SYMBOL_COUNT-1:0]       valid_r;
  logic [hufc_pkg::CODE_W-1:0]   code_r [SYMBOL_COUNT];
  logic [hufc_pkg::LEN_W-1:0]    len_r  [SYMBOL_COUNT];
  logic [SW-1:0]                 wr_idx;

  assign wr_idx = wr.symbol[SW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr.en) begin
      valid_r[wr_idx] <= wr.set;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && wr.set) begin
      code_r[wr_idx] <= wr.code;
      len_r[wr_idx]  <= wr.len;
    end
  end

  assign rd_valid = valid_r[rd_idx];

  always_comb begin
    for (int i = 0; i < SYMBOL_COUNT; i++) begin
      match[i] = valid_r[i]
              && (CLW'(len_r[i]) == CLW'(key_len))
              && (CMP_W'(code_r[i]) == CMP_W'(key_code));
    end
  end

endmodule
`default_nettype wire

### hdl/huffman_table_codec.sv
`default_nettype none
// ----------------------------------------------------------------------------
// huffman_table_codec
// Prefix-code table codec for byte symbols: table write, encode, bit decode.
// ----------------------------------------------------------------------------
// Usage
//   in_ch carries one item per beat: a table write, a symbol encode or one
//   coded bit to decode. out_ch returns exactly one result beat per item, in
//   order; a table write returns status none.
//   An item passes the stage 1, stage 2 and output registers to reach
//   out_ch. One item is taken every cycle unless out_ch stalls; the
//   partial-code loop (bit append, parallel compare against every table
//   cell, clear on hit or overflow) closes within stage 1, the winning
//   symbol is picked in stage 2, and encodes get registered code RAM data.
//   The three stages advance together: when out_ch holds a beat that is not
//   taken, in_ch.ready drops and the whole pipeline holds.
//   Synchronous reset clears the pipeline, every table valid flag and the
//   partial code; table contents stay undefined until written.
//   A decode bit that fills the partial code to the maximum length with no
//   matching entry returns a decode error and clears the partial code.
// ----------------------------------------------------------------------------
module huffman_table_codec #(
  parameter int SYMBOL_COUNT    = hufc_pkg::SYMBOL_COUNT_DEF,
  parameter int MAX_CODE_LENGTH = hufc_pkg::MAX_CODE_LENGTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  hufc_in_if.sink    in_ch,
  hufc_out_if.source out_ch
);

  localparam int SW    = $clog2(SYMBOL_COUNT);
  localparam int NLW   = $clog2(MAX_CODE_LENGTH + 1);
  localparam int PLW   = $clog2(MAX_CODE_LENGTH);
  localparam int PCW   = MAX_CODE_LENGTH - 1;
  localparam int LCW   = hufc_pkg::LEN_W + 1;
  localparam int SCW   = hufc_pkg::SYM_W + 1;

  // pipeline advance
  logic adv;

  // stage 1: accepted item
  logic               s1_valid_r;
  hufc_pkg::in_item_t s1_item_r;
  logic               s1_go;
  logic               s1_in_range;
  logic               s1_len_ok;
  logic [SW-1:0]      s1_idx;
  hufc_pkg::tbl_wr_t  tbl_wr;

  // partial code
  logic [PCW-1:0]             partial_code_r;
  logic [PLW-1:0]             partial_len_r;
  logic [MAX_CODE_LENGTH-1:0] ncode;
  logic [NLW-1:0]             nlen;
  logic                       full;
  logic                       hit;
  logic [SYMBOL_COUNT-1:0]    match;
  logic                       rd_valid;

  // stage 2
  logic                              s2_valid_r;
  logic [hufc_pkg::OP_W-1:0]         s2_op_r;
  logic [hufc_pkg::STAT_W-1:0]       s2_dec_stat_r;
  logic                              s2_enc_ok_r;
  logic [SYMBOL_COUNT-1:0]           s2_match_r;
  logic [hufc_pkg::ENTRY_W-1:0]      ram_rd_data;
  logic [SW-1:0]                     dec_sym;

  // output register
  logic                out_valid_r;
  hufc_pkg::out_item_t out_data_r;
  hufc_pkg::out_item_t out_data_nxt;

  assign adv          = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = adv;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= in_ch.valid;
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_item_r <= in_ch.data;
    end
  end

  assign s1_go       = s1_valid_r && adv;
  assign s1_idx      = s1_item_r.symbol[SW-1:0];
  assign s1_in_range = {1'b0, s1_item_r.symbol} < SCW'(SYMBOL_COUNT);
  assign s1_len_ok   = (s1_item_r.code_length != '0)
                    && ({1'b0, s1_item_r.code_length} <= LCW'(MAX_CODE_LENGTH));

  always_comb begin
    tbl_wr.en     = s1_go && (s1_item_r.operation == hufc_pkg::OP_WRITE) && s1_in_range;
    tbl_wr.set    = s1_len_ok;
    tbl_wr.symbol = s1_item_r.symbol;
    // code bits at or above the length are dropped
    tbl_wr.code   = s1_item_r.code_bits
                  & ~({hufc_pkg::CODE_W{1'b1}} << s1_item_r.code_length);
    tbl_wr.len    = s1_item_r.code_length;
  end

  assign ncode = {partial_code_r, s1_item_r.coded_bit};
  assign nlen  = NLW'(partial_len_r) + NLW'(1);
  assign full  = (nlen == NLW'(MAX_CODE_LENGTH));
  assign hit   = |match;

  hufc_cam #(
    .SYMBOL_COUNT    (SYMBOL_COUNT),
    .MAX_CODE_LENGTH (MAX_CODE_LENGTH)
  ) u_cam (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (tbl_wr),
    .key_code (ncode),
    .key_len  (nlen),
    .rd_idx   (s1_idx),
    .rd_valid (rd_valid),
    .match    (match)
  );

  hufc_ram #(
    .WIDTH (hufc_pkg::ENTRY_W),
    .DEPTH (SYMBOL_COUNT)
  ) u_code_ram (
    .clk     (clk),
    .wr_en   (tbl_wr.en && tbl_wr.set),
    .wr_addr (s1_idx),
    .wr_data ({tbl_wr.len, tbl_wr.code}),
    .rd_en   (s1_go),
    .rd_addr (s1_idx),
    .rd_data (ram_rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_code_r <= '0;
      partial_len_r  <= '0;
    end else if (s1_go && (s1_item_r.operation == hufc_pkg::OP_DECODE)) begin
      if (hit || full) begin
        partial_code_r <= '0;
        partial_len_r  <= '0;
      end else begin
        partial_code_r <= ncode[PCW-1:0];
        partial_len_r  <= nlen[PLW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_op_r     <= s1_item_r.operation;
      s2_enc_ok_r <= s1_in_range && rd_valid;
      s2_match_r  <= match;
      if (hit) begin
        s2_dec_stat_r <= hufc_pkg::ST_DECODED;
      end else if (full) begin
        s2_dec_stat_r <= hufc_pkg::ST_ERROR;
      end else begin
        s2_dec_stat_r <= hufc_pkg::ST_NONE;
      end
    end
  end

  // lowest matching symbol wins
  always_comb begin
    dec_sym = '0;
    for (int i = SYMBOL_COUNT - 1; i >= 0; i--) begin
      if (s2_match_r[i]) begin
        dec_sym = SW'(i);
      end
    end
  end

  always_comb begin
    out_data_nxt = '0;
    case (s2_op_r)
      hufc_pkg::OP_ENCODE: begin
        out_data_nxt.status = hufc_pkg::ST_EMITTED;
        if (s2_enc_ok_r) begin
          out_data_nxt.emitted_code   = ram_rd_data[hufc_pkg::CODE_W-1:0];
          out_data_nxt.emitted_length =
            ram_rd_data[hufc_pkg::ENTRY_W-1:hufc_pkg::CODE_W];
        end
      end
      hufc_pkg::OP_DECODE: begin
        out_data_nxt.status = s2_dec_stat_r;
        if (s2_dec_stat_r == hufc_pkg::ST_DECODED) begin
          out_data_nxt.decoded_symbol = hufc_pkg::SYM_W'(dec_sym);
        end
      end
      default: begin
        out_data_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule
`default_nettype wire

### test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the prefix-code table codec. A clocked driver feeds
// table writes, encodes and decode bits from a backlog that the stimulus
// process fills: a short directed pass over the corner cases, then random
// sessions that each load a fresh prefix code and stream its codewords
// through decode mixed with noise. A predictor tracks the table and partial
// code at every accepted beat, and the monitor checks each result beat in
// order against its forecast.
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic [hufc_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 2000;
  localparam int REPORT_MAX  = 10;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  hufc_in_if  in_ch();
  hufc_out_if out_ch();

  huffman_table_codec DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [hufc_pkg::CODE_W-1:0] tbl_code [hufc_pkg::SYMBOL_COUNT_DEF];
  logic [hufc_pkg::LEN_W-1:0]  tbl_len  [hufc_pkg::SYMBOL_COUNT_DEF];
  bit                          tbl_valid [hufc_pkg::SYMBOL_COUNT_DEF];
  logic [hufc_pkg::CODE_W-1:0] part_code = '0;
  logic [hufc_pkg::LEN_W-1:0]  part_len = '0;

  hufc_pkg::in_item_t  item_backlog[$];
  hufc_pkg::out_item_t result_forecast[$];

  // generator bookkeeping
  logic [hufc_pkg::SYM_W-1:0] table_syms[$];
  logic [hufc_pkg::SYM_W-1:0] stored_list[$];
  bit                         stored_flag [hufc_pkg::SYMBOL_COUNT_DEF];
  int                         gen_total = 0;

  int   idle_pct = 14;
  int   fault_count = 0;
  int   idle_cycles = 0;
  logic in_taken = 1'b0;

  function automatic logic [hufc_pkg::CODE_W-1:0] code_mask(
    logic [hufc_pkg::LEN_W-1:0] len);
    logic [31:0] m;
    m = (32'd1 << len) - 32'd1;
    return m[hufc_pkg::CODE_W-1:0];
  endfunction

  function automatic hufc_pkg::out_item_t codec_predict(hufc_pkg::in_item_t it);
    hufc_pkg::out_item_t         r;
    logic [hufc_pkg::LEN_W-1:0]  nlen;
    logic [hufc_pkg::CODE_W-1:0] ncode;
    bit                          hit;
    int                          k;
    r = '0;
    hit = 1'b0;
    case (it.operation)
      hufc_pkg::OP_WRITE: begin
        if (it.code_length >= 1 && it.code_length <= hufc_pkg::MAX_CODE_LENGTH_DEF) begin
          tbl_code[it.symbol]  = it.code_bits & code_mask(it.code_length);
          tbl_len[it.symbol]   = it.code_length;
          tbl_valid[it.symbol] = 1'b1;
        end else begin
          tbl_valid[it.symbol] = 1'b0;
        end
      end
      hufc_pkg::OP_ENCODE: begin
        r.status = hufc_pkg::ST_EMITTED;
        if (tbl_valid[it.symbol]) begin
          r.emitted_code   = tbl_code[it.symbol];
          r.emitted_length = tbl_len[it.symbol];
        end
      end
      hufc_pkg::OP_DECODE: begin
        nlen  = part_len + 5'd1;
        ncode = {part_code[hufc_pkg::CODE_W-2:0], it.coded_bit} & code_mask(nlen);
        // lowest matching symbol wins
        for (k = 0; k < hufc_pkg::SYMBOL_COUNT_DEF; k++) begin
          if (!hit && tbl_valid[k] && tbl_len[k] == nlen && tbl_code[k] == ncode) begin
            hit = 1'b1;
            r.decoded_symbol = hufc_pkg::SYM_W'(k);
          end
        end
        if (hit) begin
          r.status  = hufc_pkg::ST_DECODED;
          part_code = '0;
          part_len  = '0;
        end else if (nlen >= hufc_pkg::MAX_CODE_LENGTH_DEF) begin
          r.status  = hufc_pkg::ST_ERROR;
          part_code = '0;
          part_len  = '0;
        end else begin
          part_code = ncode;
          part_len  = nlen;
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  task automatic report_fault(string msg);
    fault_count++;
    if (fault_count <= REPORT_MAX) $display("%0t: %s", $realtime, msg);
  endtask

  task automatic add_item(hufc_pkg::in_item_t it);
    item_backlog.push_back(it);
    gen_total++;
    if (it.operation == hufc_pkg::OP_WRITE && it.code_length >= 1 &&
        it.code_length <= hufc_pkg::MAX_CODE_LENGTH_DEF && !stored_flag[it.symbol]) begin
      stored_flag[it.symbol] = 1'b1;
      stored_list.push_back(it.symbol);
    end
  endtask

  task automatic add_op(logic [hufc_pkg::OP_W-1:0] op, logic [hufc_pkg::SYM_W-1:0] sym,
                        logic [hufc_pkg::CODE_W-1:0] bits,
                        logic [hufc_pkg::LEN_W-1:0] len, logic b);
    hufc_pkg::in_item_t it;
    it.operation   = op;
    it.symbol      = sym;
    it.code_bits   = bits;
    it.code_length = len;
    it.coded_bit   = b;
    add_item(it);
  endtask

  // one session: retire the old code, load a new prefix code, then stream it
  task automatic queue_session();
    int                         lcode[$];
    int                         llen[$];
    logic [hufc_pkg::SYM_W-1:0] lsym[$];
    bit                         used [hufc_pkg::SYMBOL_COUNT_DEF];
    bit                         deep;
    int                         n, idx, c, k, j, b, m, r, s, drop;
    hufc_pkg::in_item_t         it;
    foreach (table_syms[q]) begin
      if ($urandom_range(99) < 70) begin
        it = hufc_pkg::in_item_t'($urandom);
        it.operation = hufc_pkg::OP_WRITE;
        it.symbol = table_syms[q];
        it.code_length = $urandom_range(1) ? 5'd0 : hufc_pkg::LEN_W'($urandom_range(31, 17));
        add_item(it);
      end
    end
    table_syms.delete();
    // grow a full binary tree by splitting leaves; deep sessions chain to length 16
    deep = ($urandom_range(5) == 0);
    n = deep ? hufc_pkg::MAX_CODE_LENGTH_DEF + 1 : $urandom_range(10, 2);
    lcode.push_back(0);
    llen.push_back(0);
    for (k = 1; k < n; k++) begin
      if (deep) idx = lcode.size() - 1;
      else idx = $urandom_range(lcode.size() - 1);
      c = lcode[idx];
      lcode[idx] = c << 1;
      llen[idx]  = llen[idx] + 1;
      lcode.push_back((c << 1) | 1);
      llen.push_back(llen[idx]);
    end
    for (k = 0; k < n; k++) begin
      do s = $urandom_range(255); while (used[s]);
      used[s] = 1'b1;
      lsym.push_back(hufc_pkg::SYM_W'(s));
    end
    // a missing leaf leaves a dead branch that runs into the length limit
    drop = (n > 2 && $urandom_range(4) == 0) ? $urandom_range(n - 1) : -1;
    for (k = 0; k < n; k++) begin
      if (k != drop) begin
        it = hufc_pkg::in_item_t'($urandom);
        it.operation   = hufc_pkg::OP_WRITE;
        it.symbol      = lsym[k];
        it.code_length = hufc_pkg::LEN_W'(llen[k]);
        it.code_bits   = hufc_pkg::CODE_W'(lcode[k]) | hufc_pkg::CODE_W'($urandom << llen[k]);
        add_item(it);
        table_syms.push_back(lsym[k]);
      end
    end
    if ($urandom_range(6) == 0) begin
      do k = $urandom_range(n - 1); while (k == drop);
      do s = $urandom_range(255); while (used[s]);
      used[s] = 1'b1;
      add_op(hufc_pkg::OP_WRITE, hufc_pkg::SYM_W'(s), hufc_pkg::CODE_W'(lcode[k]),
             hufc_pkg::LEN_W'(llen[k]), 1'b0);
      table_syms.push_back(hufc_pkg::SYM_W'(s));
    end
    m = $urandom_range(40, 15);
    for (j = 0; j < m; j++) begin
      r = $urandom_range(99);
      it = hufc_pkg::in_item_t'($urandom);
      if (r < 60) begin
        k = $urandom_range(n - 1);
        c = lcode[k];
        for (b = llen[k] - 1; b >= 0; b--) begin
          it = hufc_pkg::in_item_t'($urandom);
          it.operation = hufc_pkg::OP_DECODE;
          it.coded_bit = c[b];
          add_item(it);
        end
      end else if (r < 75) begin
        it.operation = hufc_pkg::OP_ENCODE;
        if (table_syms.size() != 0 && $urandom_range(1))
          it.symbol = table_syms[$urandom_range(table_syms.size() - 1)];
        else
          it.symbol = stored_list[$urandom_range(stored_list.size() - 1)];
        add_item(it);
      end else if (r < 87) begin
        it.operation = hufc_pkg::OP_DECODE;
        add_item(it);
      end else if (r < 93) begin
        it.operation = OP_UNUSED;
        add_item(it);
      end else begin
        it.operation = hufc_pkg::OP_WRITE;
        add_item(it);
      end
    end
  endtask

  task automatic queue_random(int count);
    int target;
    target = gen_total + count;
    while (gen_total < target) queue_session();
  endtask

  task automatic wait_backlog();
    while (item_backlog.size() != 0) @(posedge clk);
  endtask

  task automatic wait_drained();
    do begin
      @(posedge clk);
      #1;
    end while (item_backlog.size() != 0 || in_ch.valid || result_forecast.size() != 0);
  endtask

  // driver: new beats and ready at the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid  <= 1'b0;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= idle_pct);
      if (!in_ch.valid || in_taken) begin
        if (item_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
          in_ch.data  <= item_backlog.pop_front();
          in_ch.valid <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: forecast on input beats, check output beats
  always @(posedge clk) begin
    hufc_pkg::out_item_t want, got;
    if (rst_n) begin
      in_taken <= in_ch.valid && in_ch.ready;
      if (in_ch.valid && in_ch.ready) result_forecast.push_back(codec_predict(in_ch.data));
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (result_forecast.size() == 0) begin
          report_fault($sformatf("unexpected beat st=%0d sym=%0d code=%h len=%0d",
                                 got.status, got.decoded_symbol, got.emitted_code,
                                 got.emitted_length));
        end else begin
          want = result_forecast.pop_front();
          if (got.status !== want.status || got.decoded_symbol !== want.decoded_symbol ||
              got.emitted_code !== want.emitted_code ||
              got.emitted_length !== want.emitted_length) begin
            report_fault($sformatf(
              "mismatch want st=%0d sym=%0d code=%h len=%0d got st=%0d sym=%0d code=%h len=%0d",
              want.status, want.decoded_symbol, want.emitted_code, want.emitted_length,
              got.status, got.decoded_symbol, got.emitted_code, got.emitted_length));
          end
        end
      end
    end else begin
      in_taken <= 1'b0;
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    int i;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // undefined operation with every field high
    add_item(hufc_pkg::in_item_t'(32'hFFFF_FFFF));
    // extremes, excess code bits, symbol zero
    add_op(hufc_pkg::OP_WRITE, 8'd0, 16'hFFFE, 5'd1, 1'b0);
    add_op(hufc_pkg::OP_WRITE, 8'd255, 16'hFFFF, 5'd16, 1'b0);
    add_op(hufc_pkg::OP_WRITE, 8'd1, 16'hA5F2, 5'd2, 1'b0);
    // same code twice: lower symbol wins
    add_op(hufc_pkg::OP_WRITE, 8'd2, 16'h0002, 5'd2, 1'b0);
    add_op(hufc_pkg::OP_ENCODE, 8'd0, 16'h0000, 5'd0, 1'b0);
    add_op(hufc_pkg::OP_ENCODE, 8'd255, 16'h0000, 5'd0, 1'b0);
    add_op(hufc_pkg::OP_DECODE, 8'd0, 16'h0000, 5'd0, 1'b0);
    add_op(hufc_pkg::OP_DECODE, 8'd0, 16'h0000, 5'd0, 1'b1);
    add_op(hufc_pkg::OP_DECODE, 8'd0, 16'h0000, 5'd0, 1'b0);
    // bad lengths clear the entry
    add_op(hufc_pkg::OP_WRITE, 8'd1, 16'h0002, 5'd0, 1'b0);
    add_op(hufc_pkg::OP_ENCODE, 8'd1, 16'h0000, 5'd0, 1'b0);
    add_op(hufc_pkg::OP_WRITE, 8'd255, 16'hFFFF, 5'd17, 1'b0);
    // sixteen ones with no entry: decode error at full length
    for (i = 0; i < hufc_pkg::MAX_CODE_LENGTH_DEF; i++)
      add_op(hufc_pkg::OP_DECODE, 8'd0, 16'h0000, 5'd0, 1'b1);
    wait_drained();

    queue_random(180);
    wait_drained();
    idle_pct = 0;
    queue_random(110);
    wait_backlog();
    idle_pct = 14;
    queue_random(120);
    wait_drained();
    repeat (12) @(posedge clk);

    fault_count += result_forecast.size();
    if (fault_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
